/* src/dvpa_pkg.sv */
// ----------------------------------------------------------------------------
// dvpa_pkg: shared types and constants
// Item and result types and the fixed widths of the angle datapath.
// ----------------------------------------------------------------------------
package dvpa_pkg;

    localparam int COMPONENT_WIDTH = 24;
    localparam int FRACTION_BITS   = 14;

    // root bits before final rounding: one guard bit and one integer bit
    localparam int QW  = FRACTION_BITS + 2;
    // shift amount width, holds QW itself
    localparam int SW  = $clog2(QW) + 1;
    // squares and sums of squares
    localparam int DW  = 2 * COMPONENT_WIDTH;
    // running q times denominator
    localparam int AW  = DW + QW;
    // remainder and trial width
    localparam int TW  = DW + 2 * QW + 1;
    // rounded ratio, 0 .. 2^FRACTION_BITS
    localparam int MW  = FRACTION_BITS + 1;

    typedef struct packed {
        logic signed [COMPONENT_WIDTH-1:0] vec_x;
        logic signed [COMPONENT_WIDTH-1:0] vec_y;
        logic signed [COMPONENT_WIDTH-1:0] vec_z;
    } t_item;

    typedef struct packed {
        logic signed [15:0] cos_theta;
        logic        [14:0] sin_theta;
        logic signed [15:0] cos_phi;
        logic signed [15:0] sin_phi;
        logic               needs_rotation;
        logic               zero_vector;
    } t_result;

    typedef struct packed {
        logic neg_x;
        logic neg_y;
        logic neg_z;
        logic r2_zero;
        logic s2_zero;
    } t_side;

endpackage

/* src/direction_vector_to_polar_angles.sv */
// ----------------------------------------------------------------------------
// direction_vector_to_polar_angles: vector to polar angle sines and cosines
// Normalizes a 3D vector and gives cos/sin of polar angle and azimuth.
// ----------------------------------------------------------------------------
// channel   signals                       direction  accept
// item      start, busy, i_item           in         start & !busy
// result    o_valid, o_result             out        o_valid (one cycle)
//
// one item per cycle; busy is always low
// stages in order: magnitude and square, sums, 16 root cells, output register
// the four ratios each run through their own row of 16 cells, one bit per cell
// reset clears only the valid line; payload registers are not reset
// results cannot be held off, each stands for exactly one cycle
// ----------------------------------------------------------------------------
module direction_vector_to_polar_angles (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  dvpa_pkg::t_item   i_item,
    output logic              o_valid,
    output dvpa_pkg::t_result o_result
);

    localparam int CW = dvpa_pkg::COMPONENT_WIDTH;
    localparam int DW = dvpa_pkg::DW;
    localparam int QW = dvpa_pkg::QW;
    localparam int MW = dvpa_pkg::MW;

    // magnitude of each component, full-scale negative stays exact
    logic [CW-1:0] mag_x, mag_y, mag_z;

    // stage 1: squares
    logic [DW-1:0]       r_sq_x, r_sq_y, r_sq_z;
    dvpa_pkg::t_side     r_side1;
    logic                r_vld1;

    // stage 2: sums of squares
    logic [DW-1:0]       r_sq_x2, r_sq_y2, r_sq_z2, r_r2, r_s2;
    logic [DW-1:0]       n_r2;
    dvpa_pkg::t_side     r_side2;
    logic                r_vld2;

    // sideband travels beside the root cells
    dvpa_pkg::t_side     r_side_line [QW];
    logic [QW-1:0]       r_vld_line;

    logic [MW-1:0]       ct, st, cp, sp;
    dvpa_pkg::t_side     side_end;
    dvpa_pkg::t_result   n_result;
    dvpa_pkg::t_result   r_result;
    logic                r_valid;

    assign busy = 1'b0;

    always_comb begin
        mag_x = i_item.vec_x[CW-1] ? (CW'(0) - i_item.vec_x) : i_item.vec_x;
        mag_y = i_item.vec_y[CW-1] ? (CW'(0) - i_item.vec_y) : i_item.vec_y;
        mag_z = i_item.vec_z[CW-1] ? (CW'(0) - i_item.vec_z) : i_item.vec_z;
    end

    always_ff @(posedge i_clk) begin
        r_sq_x <= DW'(mag_x) * DW'(mag_x);
        r_sq_y <= DW'(mag_y) * DW'(mag_y);
        r_sq_z <= DW'(mag_z) * DW'(mag_z);
        r_side1.neg_x   <= i_item.vec_x[CW-1];
        r_side1.neg_y   <= i_item.vec_y[CW-1];
        r_side1.neg_z   <= i_item.vec_z[CW-1];
        r_side1.r2_zero <= 1'b0;
        r_side1.s2_zero <= 1'b0;
    end

    assign n_r2 = r_sq_x + r_sq_y;

    always_ff @(posedge i_clk) begin
        r_sq_x2 <= r_sq_x;
        r_sq_y2 <= r_sq_y;
        r_sq_z2 <= r_sq_z;
        r_r2    <= n_r2;
        r_s2    <= n_r2 + r_sq_z;
        r_side2.neg_x   <= r_side1.neg_x;
        r_side2.neg_y   <= r_side1.neg_y;
        r_side2.neg_z   <= r_side1.neg_z;
        r_side2.r2_zero <= (n_r2 == '0);
        r_side2.s2_zero <= (n_r2 == '0) && (r_sq_z == '0);
    end

    // four ratio rows
    dvpa_root_chain u_cos_theta (
        .i_clk(i_clk), .i_num(r_sq_z2), .i_den(r_s2), .o_ratio(ct)
    );
    dvpa_root_chain u_sin_theta (
        .i_clk(i_clk), .i_num(r_r2), .i_den(r_s2), .o_ratio(st)
    );
    dvpa_root_chain u_cos_phi (
        .i_clk(i_clk), .i_num(r_sq_x2), .i_den(r_r2), .o_ratio(cp)
    );
    dvpa_root_chain u_sin_phi (
        .i_clk(i_clk), .i_num(r_sq_y2), .i_den(r_r2), .o_ratio(sp)
    );

    always_ff @(posedge i_clk) begin
        r_side_line[0] <= r_side2;
        for (int i = 1; i < QW; i++) begin
            r_side_line[i] <= r_side_line[i-1];
        end
    end

    // valid line, reset clears it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1     <= 1'b0;
            r_vld2     <= 1'b0;
            r_vld_line <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_vld1     <= start & ~busy;
            r_vld2     <= r_vld1;
            r_vld_line <= {r_vld_line[QW-2:0], r_vld2};
            r_valid    <= r_vld_line[QW-1];
        end
    end

    assign side_end = r_side_line[QW-1];

    // result assembly, zero vector and z axis handled here
    always_comb begin
        n_result = '0;
        if (side_end.s2_zero) begin
            n_result.needs_rotation = 1'b1;
            n_result.zero_vector    = 1'b1;
        end else begin
            n_result.cos_theta = side_end.neg_z ? (16'd0 - 16'(ct)) : 16'(ct);
            n_result.sin_theta = 15'(st);
            if (side_end.r2_zero) begin
                n_result.cos_phi = 16'(1 << dvpa_pkg::FRACTION_BITS);
                n_result.sin_phi = '0;
            end else begin
                n_result.cos_phi = side_end.neg_x ? (16'd0 - 16'(cp)) : 16'(cp);
                n_result.sin_phi = side_end.neg_y ? (16'd0 - 16'(sp)) : 16'(sp);
            end
            n_result.needs_rotation = !(side_end.r2_zero && !side_end.neg_z);
            n_result.zero_vector    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

/* src/dvpa_cell.sv */
// ----------------------------------------------------------------------------
// dvpa_cell: one root digit
// Decides one bit of floor(sqrt(num * 2^(2QW-2) / den)) by trial subtraction.
// ----------------------------------------------------------------------------
module dvpa_cell (
    input  logic                    i_clk,
    input  logic [dvpa_pkg::SW-1:0] i_step,
    input  logic [dvpa_pkg::TW-1:0] i_rem,
    input  logic [dvpa_pkg::AW-1:0] i_acc,
    input  logic [dvpa_pkg::DW-1:0] i_den,
    input  logic [dvpa_pkg::QW-1:0] i_q,
    output logic [dvpa_pkg::TW-1:0] o_rem,
    output logic [dvpa_pkg::AW-1:0] o_acc,
    output logic [dvpa_pkg::DW-1:0] o_den,
    output logic [dvpa_pkg::QW-1:0] o_q
);

    logic [dvpa_pkg::SW-1:0] step_p1;
    logic [dvpa_pkg::TW-1:0] trial;
    logic [dvpa_pkg::AW-1:0] den_sh;
    logic                    fits;
    logic [dvpa_pkg::TW-1:0] n_rem;
    logic [dvpa_pkg::AW-1:0] n_acc;
    logic [dvpa_pkg::QW-1:0] n_q;
    logic [dvpa_pkg::TW-1:0] r_rem;
    logic [dvpa_pkg::AW-1:0] r_acc;
    logic [dvpa_pkg::DW-1:0] r_den;
    logic [dvpa_pkg::QW-1:0] r_q;

    // (q + 2^k)^2 den - q^2 den = 2^(k+1) q den + 2^(2k) den
    always_comb begin
        step_p1 = i_step + dvpa_pkg::SW'(1);
        trial   = (dvpa_pkg::TW'(i_acc) << step_p1)
                + (dvpa_pkg::TW'(i_den) << {i_step, 1'b0});
        den_sh  = dvpa_pkg::AW'(i_den) << i_step;
        fits    = (trial <= i_rem);
        n_rem   = fits ? (i_rem - trial) : i_rem;
        n_acc   = fits ? (i_acc + den_sh) : i_acc;
        n_q     = fits ? (i_q | (dvpa_pkg::QW'(1) << i_step)) : i_q;
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_acc <= n_acc;
        r_den <= i_den;
        r_q   <= n_q;
    end

    assign o_rem = r_rem;
    assign o_acc = r_acc;
    assign o_den = r_den;
    assign o_q   = r_q;

endmodule

/* src/dvpa_root_chain.sv */
// ----------------------------------------------------------------------------
// dvpa_root_chain: row of root cells
// round(2^F * sqrt(num / den)) with ties up, one new pair per cycle.
// ----------------------------------------------------------------------------
module dvpa_root_chain (
    input  logic                    i_clk,
    input  logic [dvpa_pkg::DW-1:0] i_num,
    input  logic [dvpa_pkg::DW-1:0] i_den,
    output logic [dvpa_pkg::MW-1:0] o_ratio
);

    logic [dvpa_pkg::TW-1:0] rem [dvpa_pkg::QW+1];
    logic [dvpa_pkg::AW-1:0] acc [dvpa_pkg::QW+1];
    logic [dvpa_pkg::DW-1:0] den [dvpa_pkg::QW+1];
    logic [dvpa_pkg::QW-1:0] q   [dvpa_pkg::QW+1];
    logic [dvpa_pkg::QW:0]   q_p1;

    assign rem[0] = dvpa_pkg::TW'(i_num) << (2 * dvpa_pkg::QW - 2);
    assign acc[0] = '0;
    assign den[0] = i_den;
    assign q[0]   = '0;

    for (genvar i = 0; i < dvpa_pkg::QW; i++) begin : g_cell
        dvpa_cell u_cell (
            .i_clk  (i_clk),
            .i_step (dvpa_pkg::SW'(dvpa_pkg::QW - 1 - i)),
            .i_rem  (rem[i]),
            .i_acc  (acc[i]),
            .i_den  (den[i]),
            .i_q    (q[i]),
            .o_rem  (rem[i+1]),
            .o_acc  (acc[i+1]),
            .o_den  (den[i+1]),
            .o_q    (q[i+1])
        );
    end

    // largest m with (2m-1) <= q
    assign q_p1    = {1'b0, q[dvpa_pkg::QW]} + (dvpa_pkg::QW+1)'(1);
    assign o_ratio = q_p1[dvpa_pkg::MW:1];

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for direction_vector_to_polar_angles
// Random and corner vectors go in with random gaps; each result is checked
// field by field against an exact integer prediction of the four ratios.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int LATENCY   = 19;
    localparam int MAX_CYCLE = 400000;
    localparam int CW        = dvpa_pkg::COMPONENT_WIDTH;
    localparam int DW        = dvpa_pkg::DW;
    localparam int MW        = dvpa_pkg::MW;
    localparam int FB        = dvpa_pkg::FRACTION_BITS;
    localparam int FMAX      = (1 << (CW - 1)) - 1;
    localparam int FMIN      = -(1 << (CW - 1));

    logic              i_clk;
    logic              i_rst_n = 1'b0;
    logic              start   = 1'b0;
    logic              busy;
    dvpa_pkg::t_item   i_item  = '0;
    logic              o_valid;
    dvpa_pkg::t_result o_result;

    direction_vector_to_polar_angles dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    // clock, 10 ns period
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    dvpa_pkg::t_item   pending_items[$];
    dvpa_pkg::t_result expected_angles[$];
    int      n_errors       = 0;
    int      n_checked      = 0;
    int      n_sent         = 0;
    int      cycle_count    = 0;
    int      gap_left       = 0;
    bit      stim_done      = 1'b0;
    bit      hold_for_drain = 1'b0;

    // round(2^F * sqrt(num2/den)), ties up, by bisection on the odd numerator
    function automatic logic [MW-1:0] root_ratio(input logic [DW-1:0] num2,
                                                 input logic [DW-1:0] den);
        logic [127:0]  lhs;
        logic [127:0]  rhs;
        logic [MW:0]   lo;
        logic [MW:0]   hi;
        logic [MW:0]   mid;
        logic [MW+1:0] odd;
        lo  = '0;
        hi  = (MW+1)'(1 << FB);
        rhs = 128'(num2) << (2 * FB + 2);
        while (lo < hi) begin
            mid = (MW+1)'((32'(lo) + 32'(hi) + 32'd1) >> 1);
            odd = (MW+2)'(2 * 32'(mid) - 32'd1);
            lhs = 128'(odd) * 128'(odd) * 128'(den);
            if (lhs <= rhs) begin
                lo = mid;
            end else begin
                hi = mid - (MW+1)'(1);
            end
        end
        return lo[MW-1:0];
    endfunction

    function automatic logic [15:0] apply_sign(input logic neg, input logic [MW-1:0] m);
        logic [15:0] v;
        v = 16'(m);
        return neg ? -v : v;
    endfunction

    function automatic dvpa_pkg::t_result predict_angles(input dvpa_pkg::t_item it);
        dvpa_pkg::t_result r;
        logic [CW-1:0] mx, my, mz;
        logic [DW-1:0] r2, s2;
        logic nx, ny, nz;
        nx = it.vec_x[CW-1];
        ny = it.vec_y[CW-1];
        nz = it.vec_z[CW-1];
        // full-scale negative magnitude fits unsigned in the same width
        mx = nx ? -it.vec_x : it.vec_x;
        my = ny ? -it.vec_y : it.vec_y;
        mz = nz ? -it.vec_z : it.vec_z;
        r2 = DW'(mx) * DW'(mx) + DW'(my) * DW'(my);
        s2 = r2 + DW'(mz) * DW'(mz);
        r  = '0;
        if (s2 == '0) begin
            // zero vector: angles zero, both flags set
            r.needs_rotation = 1'b1;
            r.zero_vector    = 1'b1;
            return r;
        end
        r.cos_theta = apply_sign(nz, root_ratio(DW'(mz) * DW'(mz), s2));
        r.sin_theta = 15'(root_ratio(r2, s2));
        if (r2 == '0) begin
            // on the z axis the azimuth defaults to +x
            r.cos_phi = 16'(1 << FB);
            r.sin_phi = '0;
        end else begin
            r.cos_phi = apply_sign(nx, root_ratio(DW'(mx) * DW'(mx), r2));
            r.sin_phi = apply_sign(ny, root_ratio(DW'(my) * DW'(my), r2));
        end
        r.needs_rotation = !(r2 == '0 && !nz);
        return r;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        n_errors++;
        $display("mismatch at result %0d: %s got %0d want %0d", n_checked, field, got, want);
    endtask

    function automatic logic [CW-1:0] rand_comp();
        int sel;
        logic [CW-1:0] v;
        sel = $urandom_range(0, 9);
        v   = CW'($urandom);
        case (sel)
            0: v = CW'($urandom_range(0, 4)) - CW'(2);
            1: v = {1'b1, {(CW-1){1'b0}}};
            2: v = {1'b0, {(CW-1){1'b1}}};
            3: v = CW'($signed(v) >>> $urandom_range(0, CW - 1));
            4: v = '0;
            default: ;
        endcase
        return v;
    endfunction

    task automatic add_item(input int x, input int y, input int z);
        dvpa_pkg::t_item it;
        it.vec_x = CW'(x);
        it.vec_y = CW'(y);
        it.vec_z = CW'(z);
        pending_items.push_back(it);
    endtask

    // stimulus: directed corners, then random vectors in two halves
    initial begin
        dvpa_pkg::t_item it;
        add_item(0, 0, 0);          // zero vector
        add_item(0, 0, 5);          // exactly +z
        add_item(0, 0, -5);         // exactly -z
        add_item(0, 0, FMIN);       // -z, full-scale negative
        add_item(0, 0, FMAX);
        add_item(FMIN, 0, 0);
        add_item(0, FMIN, 0);
        add_item(FMAX, 0, 0);
        add_item(0, FMAX, 0);
        add_item(FMIN, FMIN, FMIN);
        add_item(FMAX, FMAX, FMAX);
        add_item(FMIN, FMAX, FMIN);
        add_item(1, 1, 1);
        add_item(-1, -1, -1);
        add_item(1, 0, 3);          // steep, near the z axis
        add_item(3, 4, 100);
        add_item(-3, 4, -100);
        add_item(1, 1, FMAX);
        add_item(-1, 0, FMIN);
        add_item(FMAX, 1, 0);
        add_item(3, 4, 0);
        add_item(-3, -4, 12);
        for (int i = 0; i < 1330; i++) begin
            if (i == 660) begin
                // let the pipe run dry once
                wait (pending_items.size() == 0);
                hold_for_drain = 1'b1;
                @(posedge i_clk);
                wait (!start && expected_angles.size() == 0);
                @(posedge i_clk);
                hold_for_drain = 1'b0;
            end
            it.vec_x = rand_comp();
            it.vec_y = rand_comp();
            it.vec_z = rand_comp();
            pending_items.push_back(it);
        end
        stim_done = 1'b1;
    end

    // driver: reset, then items from the queue with random gaps
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count < 4) begin
            i_rst_n <= 1'b0;
            start   <= 1'b0;
            i_item  <= '0;
        end else begin
            i_rst_n <= 1'b1;
            if (start && !busy) begin
                expected_angles.push_back(predict_angles(i_item));
                n_sent <= n_sent + 1;
            end
            if (!(start && busy)) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    start    <= 1'b0;
                end else if (pending_items.size() > 0 && !hold_for_drain) begin
                    start  <= 1'b1;
                    i_item <= pending_items.pop_front();
                    // mostly back to back, sometimes short gaps, rarely long
                    case ($urandom_range(0, 19))
                        0:       gap_left <= $urandom_range(10, 40);
                        1, 2, 3: gap_left <= $urandom_range(1, 3);
                        default: gap_left <= 0;
                    endcase
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each strobed result with the oldest prediction
    always @(posedge i_clk) begin
        dvpa_pkg::t_result want;
        if (i_rst_n && o_valid) begin
            if (expected_angles.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                want = expected_angles.pop_front();
                if (o_result.cos_theta !== want.cos_theta)
                    report_mismatch("cos_theta", o_result.cos_theta, want.cos_theta);
                if (o_result.sin_theta !== want.sin_theta)
                    report_mismatch("sin_theta", o_result.sin_theta, want.sin_theta);
                if (o_result.cos_phi !== want.cos_phi)
                    report_mismatch("cos_phi", o_result.cos_phi, want.cos_phi);
                if (o_result.sin_phi !== want.sin_phi)
                    report_mismatch("sin_phi", o_result.sin_phi, want.sin_phi);
                if (o_result.needs_rotation !== want.needs_rotation)
                    report_mismatch("needs_rotation", o_result.needs_rotation,
                                    want.needs_rotation);
                if (o_result.zero_vector !== want.zero_vector)
                    report_mismatch("zero_vector", o_result.zero_vector, want.zero_vector);
                n_checked++;
            end
        end
    end

    // end of run and watchdog
    initial begin
        fork
            begin
                wait (stim_done && pending_items.size() == 0 && !start);
                wait (expected_angles.size() == 0);
                repeat (LATENCY + 10) @(posedge i_clk);
                $display("covered %0d vectors, %0d results checked (axes, zero, full scale)",
                         n_sent, n_checked);
                if (n_errors == 0 && expected_angles.size() == 0) begin
                    $display("tb_top passed");
                end else begin
                    $display("tb_top failed");
                end
                $finish;
            end
            begin
                wait (cycle_count >= MAX_CYCLE);
                $display("timeout after %0d cycles", cycle_count);
                $display("tb_top failed");
                $finish;
            end
        join
    end

endmodule

/* direction_vector_to_polar_angles.f */
src/dvpa_pkg.sv
src/dvpa_cell.sv
src/dvpa_root_chain.sv
src/direction_vector_to_polar_angles.sv
tb/tb_top.sv
